// ===== hw/rtl/lfdc_pkg.sv =====
package lfdc_pkg;

  localparam int unsigned SpeedW = 8;
  localparam int unsigned DistW = 10;
  localparam int unsigned TrackW = 5;
  localparam int unsigned DebW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DebW-1:0] DEBOUNCE_RESET = 16'd20;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [TrackW-1:0] TRACK_NONE = 5'h00;

  localparam logic [CfgIdxW-1:0] REG_BASE_SPEED = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOST_SPEED = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TURN_SPEED = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STOP_DIST = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 3'd4;

  typedef enum logic [1:0] {
    DB_IDLE,
    DB_CONFIRM_PRESS,
    DB_HOLD,
    DB_CONFIRM_RELEASE
  } db_phase_t;

endpackage

// ===== hw/rtl/line_follow_drive_commander.sv =====
// the result beat is registered and shows in the cycle after its input beat is accepted
// throughput: one input beat per cycle while the result side keeps taking beats
// the result registers double as the control state, so a new beat is taken
// whenever the result slot is empty or being taken in the same cycle
// reset (rst, synchronous): disabled, stop, zero speeds and distance,
// debouncer idle, debounce_ms 20, other config registers 0
module line_follow_drive_commander (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                distance_valid,
  input  logic [lfdc_pkg::DistW-1:0]          distance_cm,
  input  logic                                track_valid,
  input  logic [lfdc_pkg::TrackW-1:0]         track_bits,
  input  logic                                button_down,
  input  logic [lfdc_pkg::TimeW-1:0]          now_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                enabled,
  output logic [1:0]                          direction,
  output logic [lfdc_pkg::SpeedW-1:0]         left_front_speed,
  output logic [lfdc_pkg::SpeedW-1:0]         left_rear_speed,
  output logic [lfdc_pkg::SpeedW-1:0]         right_front_speed,
  output logic [lfdc_pkg::SpeedW-1:0]         right_rear_speed,
  output logic [lfdc_pkg::DistW-1:0]          obstacle_cm,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfdc_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [lfdc_pkg::CfgDataW-1:0]       cfg_data
);

  logic [lfdc_pkg::SpeedW-1:0] base_speed;
  logic [lfdc_pkg::SpeedW-1:0] lost_speed;
  logic [lfdc_pkg::SpeedW-1:0] turn_speed;
  logic [lfdc_pkg::DistW-1:0]  stop_distance_cm;
  logic [lfdc_pkg::DebW-1:0]   debounce_ms;

  lfdc_pkg::db_phase_t         phase, phase_next;
  logic [lfdc_pkg::TimeW-1:0]  db_start, db_start_next;

  logic                        enabled_next;
  logic [1:0]                  direction_next;
  logic [lfdc_pkg::SpeedW-1:0] lf_next, lr_next, rf_next, rr_next;
  logic [lfdc_pkg::DistW-1:0]  obstacle_next;
  logic                        out_valid_next;

  logic                        accept;
  logic                        press;
  logic                        elapsed;
  logic [lfdc_pkg::TimeW-1:0]  age;
  logic [1:0]                  left_weight, right_weight;
  logic [lfdc_pkg::DistW-1:0]  dist_now;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed       <= '0;
      lost_speed       <= '0;
      turn_speed       <= '0;
      stop_distance_cm <= '0;
      debounce_ms      <= lfdc_pkg::DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lfdc_pkg::REG_BASE_SPEED: base_speed <= cfg_data[lfdc_pkg::SpeedW-1:0];
        lfdc_pkg::REG_LOST_SPEED: lost_speed <= cfg_data[lfdc_pkg::SpeedW-1:0];
        lfdc_pkg::REG_TURN_SPEED: turn_speed <= cfg_data[lfdc_pkg::SpeedW-1:0];
        lfdc_pkg::REG_STOP_DIST:  stop_distance_cm <= cfg_data[lfdc_pkg::DistW-1:0];
        lfdc_pkg::REG_DEBOUNCE:   debounce_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // debouncer, runs on every pass
  assign age     = now_ms - db_start;
  assign elapsed = age >= {{(lfdc_pkg::TimeW-lfdc_pkg::DebW){1'b0}}, debounce_ms};

  always_comb begin
    phase_next    = phase;
    db_start_next = db_start;
    press         = 1'b0;
    unique case (phase)
      lfdc_pkg::DB_IDLE: begin
        if (button_down) begin
          db_start_next = now_ms;
          phase_next    = lfdc_pkg::DB_CONFIRM_PRESS;
        end
      end
      lfdc_pkg::DB_CONFIRM_PRESS: begin
        if (elapsed) begin
          if (button_down) begin
            press      = 1'b1;
            phase_next = lfdc_pkg::DB_HOLD;
          end else begin
            phase_next = lfdc_pkg::DB_IDLE;
          end
        end
      end
      lfdc_pkg::DB_HOLD: begin
        if (!button_down) begin
          db_start_next = now_ms;
          phase_next    = lfdc_pkg::DB_CONFIRM_RELEASE;
        end
      end
      lfdc_pkg::DB_CONFIRM_RELEASE: begin
        if (elapsed) begin
          phase_next = button_down ? lfdc_pkg::DB_HOLD : lfdc_pkg::DB_IDLE;
        end
      end
      default: phase_next = lfdc_pkg::DB_IDLE;
    endcase
  end

  // centroid sign: outer sensors weigh two, inner ones weigh one
  assign left_weight  = {track_bits[4], 1'b0} + {1'b0, track_bits[3]};
  assign right_weight = {track_bits[0], 1'b0} + {1'b0, track_bits[1]};
  assign dist_now     = distance_valid ? distance_cm : obstacle_cm;

  always_comb begin
    enabled_next   = enabled;
    direction_next = direction;
    lf_next        = left_front_speed;
    lr_next        = left_rear_speed;
    rf_next        = right_front_speed;
    rr_next        = right_rear_speed;
    obstacle_next  = obstacle_cm;
    if (!enabled) begin
      direction_next = lfdc_pkg::DIR_STOP;
      obstacle_next  = '0;
      if (press) begin
        enabled_next = 1'b1;
      end
    end else begin
      obstacle_next = dist_now;
      if (track_valid) begin
        priority if (track_bits == lfdc_pkg::TRACK_NONE) begin
          direction_next = lfdc_pkg::DIR_FORWARD;
          {lf_next, lr_next, rf_next, rr_next} = {4{lost_speed}};
        end else if (left_weight == right_weight) begin
          direction_next = lfdc_pkg::DIR_FORWARD;
          {lf_next, lr_next, rf_next, rr_next} = {4{base_speed}};
        end else if (left_weight > right_weight) begin
          direction_next = lfdc_pkg::DIR_LEFT;
          {lf_next, lr_next, rf_next, rr_next} = {16'd0, turn_speed, turn_speed};
        end else begin
          direction_next = lfdc_pkg::DIR_RIGHT;
          {lf_next, lr_next, rf_next, rr_next} = {turn_speed, turn_speed, 16'd0};
        end
      end
      // zero distance means no echo, zero threshold never stops
      if (dist_now != '0 && dist_now <= stop_distance_cm) begin
        direction_next = lfdc_pkg::DIR_STOP;
        {lf_next, lr_next, rf_next, rr_next} = '0;
      end
      if (press) begin
        direction_next = lfdc_pkg::DIR_STOP;
        enabled_next   = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= lfdc_pkg::DB_IDLE;
      db_start          <= '0;
      enabled           <= 1'b0;
      direction         <= lfdc_pkg::DIR_STOP;
      left_front_speed  <= '0;
      left_rear_speed   <= '0;
      right_front_speed <= '0;
      right_rear_speed  <= '0;
      obstacle_cm       <= '0;
      out_valid         <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        phase             <= phase_next;
        db_start          <= db_start_next;
        enabled           <= enabled_next;
        direction         <= direction_next;
        left_front_speed  <= lf_next;
        left_rear_speed   <= lr_next;
        right_front_speed <= rf_next;
        right_rear_speed  <= rr_next;
        obstacle_cm       <= obstacle_next;
      end
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result beat");

  // a press that disables still takes the current distance, cleared on the next pass
  a_disabled_stops: assert property (@(posedge clk) disable iff (rst)
    !enabled |-> (direction == lfdc_pkg::DIR_STOP))
    else $error("disabled system not stopped");

  a_enable_only_on_beat: assert property (@(posedge clk)
    (!rst && !accept) |=> $stable(enabled))
    else $error("enable changed without an input beat");

endmodule
